// ----- rtl/mbsf_pkg.sv -----
// Package for the MIDI byte stream framer.
// Holds byte codes, result kinds, the status length table and function, the
// controller state type and the command/status structs. No dependencies.
package mbsf_pkg;

    localparam int SYSEX_CAPACITY_DEF = 32;

    localparam logic [7:0] BYTE_REALTIME = 8'hF8;
    localparam logic [7:0] BYTE_SYSEX    = 8'hF0;
    localparam logic [7:0] BYTE_EOX      = 8'hF7;

    localparam logic [1:0] KIND_SHORT = 2'd0;
    localparam logic [1:0] KIND_RT    = 2'd1;
    localparam logic [1:0] KIND_SYSEX = 2'd2;

    localparam logic [1:0] SYS_LEN [16] = '{
        2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd0,
        2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SX_READ,
        ST_SX_SEND,
        ST_MSG
    } t_state;

    typedef struct packed {
        logic load_byte;
        logic rt_emit;
        logic sx_store;
        logic sx_close;
        logic sx_read;
        logic sx_emit;
        logic msg_commit;
    } t_cmd;

    typedef struct packed {
        logic is_rt;
        logic is_status;
        logic rs_sysex;
        logic msg_emit;
        logic slot_free;
        logic sx_done;
    } t_status;

    function automatic logic [1:0] len_of(input logic [7:0] s);
        logic [1:0] r;
        if (!s[7]) begin
            r = 2'd0;
        end else if (s[7:4] == 4'hC || s[7:4] == 4'hD) begin
            r = 2'd2;
        end else if (s[7:4] == 4'hF) begin
            r = SYS_LEN[s[3:0]];
        end else begin
            r = 2'd3;
        end
        return r;
    endfunction

endpackage

// ----- rtl/mbsf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mbsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/mbsf_datapath.sv -----
// Datapath of the framer: byte holding register, running status, message
// assembly, sysex store and count, output register.
// Depends on mbsf_pkg and mbsf_ram.
module mbsf_datapath import mbsf_pkg::*; #(
    parameter int SYSEX_CAPACITY = SYSEX_CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_data_byte,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic [1:0] o_kind,
    output logic [7:0] o_byte_zero,
    output logic [7:0] o_byte_one,
    output logic [7:0] o_byte_two,
    output logic [1:0] o_msg_length,
    output logic       o_last
);

    localparam int AW = $clog2(SYSEX_CAPACITY);
    localparam int CW = $clog2(SYSEX_CAPACITY + 1);

    logic [7:0]    r_byte;
    logic [7:0]    r_rs,    n_rs;
    logic [1:0]    r_exp,   n_exp;
    logic [1:0]    r_fill,  n_fill;
    logic [7:0]    r_mb [3];
    logic [7:0]    n_mb [3];
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx,   n_idx;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_kind,  n_kind;
    logic [7:0]    r_b0,    n_b0;
    logic [7:0]    r_b1,    n_b1;
    logic [7:0]    r_b2,    n_b2;
    logic [1:0]    r_len,   n_len;
    logic          r_last,  n_last;

    logic          is_status;
    logic [1:0]    b_len;
    logic [1:0]    eff_exp;
    logic [1:0]    eff_fill;
    logic [1:0]    nf;
    logic          msg_emit;
    logic [7:0]    new_mb [3];
    logic          slot_free;
    logic          sx_done;

    logic          ram_we;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic [7:0]    ram_rd_data;

    assign is_status = r_byte[7];
    assign b_len     = len_of(r_byte);
    assign eff_exp   = is_status ? b_len : r_exp;
    assign eff_fill  = is_status ? 2'd0 : r_fill;
    assign nf        = eff_fill + 2'd1;
    assign msg_emit  = (eff_exp != 2'd0) && (nf >= eff_exp);
    assign slot_free = !r_out_valid || !i_out_stall;
    assign sx_done   = (r_idx == r_count - CW'(1));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            new_mb[k] = (eff_exp != 2'd0 && eff_fill == 2'(k)) ? r_byte : r_mb[k];
        end
    end

    assign o_status.is_rt     = (r_byte >= BYTE_REALTIME);
    assign o_status.is_status = is_status;
    assign o_status.rs_sysex  = (r_rs == BYTE_SYSEX);
    assign o_status.msg_emit  = msg_emit;
    assign o_status.slot_free = slot_free;
    assign o_status.sx_done   = sx_done;

    // sysex store write port
    always_comb begin
        ram_we      = 1'b0;
        ram_wr_addr = r_count[AW-1:0];
        ram_wr_data = r_byte;
        if (i_cmd.sx_store && r_count < CW'(SYSEX_CAPACITY - 1)) begin
            ram_we = 1'b1;
        end
        if (i_cmd.sx_close) begin
            ram_we      = 1'b1;
            ram_wr_data = BYTE_EOX;
        end
        if (i_cmd.msg_commit && r_byte == BYTE_SYSEX) begin
            ram_we      = 1'b1;
            ram_wr_addr = '0;
            ram_wr_data = BYTE_SYSEX;
        end
    end

    mbsf_ram #(
        .WIDTH (8),
        .DEPTH (SYSEX_CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_re      (i_cmd.sx_read),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // framing state
    always_comb begin
        n_rs    = r_rs;
        n_exp   = r_exp;
        n_fill  = r_fill;
        n_mb    = r_mb;
        n_count = r_count;
        n_idx   = r_idx;
        if (i_cmd.sx_store && r_count < CW'(SYSEX_CAPACITY - 1)) begin
            n_count = r_count + CW'(1);
        end
        if (i_cmd.sx_close) begin
            n_count = r_count + CW'(1);
            n_idx   = '0;
        end
        if (i_cmd.sx_emit) begin
            n_idx = r_idx + CW'(1);
        end
        if (i_cmd.msg_commit) begin
            if (is_status) begin
                n_rs   = r_byte;
                n_exp  = b_len;
                n_fill = 2'd0;
                if (r_byte == BYTE_SYSEX) begin
                    n_count = CW'(1);
                end
            end
            if (eff_exp != 2'd0) begin
                n_mb   = new_mb;
                n_fill = msg_emit ? 2'd1 : nf;
            end
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_b0        = r_b0;
        n_b1        = r_b1;
        n_b2        = r_b2;
        n_len       = r_len;
        n_last      = r_last;
        if (i_cmd.rt_emit) begin
            n_out_valid = 1'b1;
            n_kind      = KIND_RT;
            n_b0        = r_byte;
            n_b1        = '0;
            n_b2        = '0;
            n_len       = 2'd1;
            n_last      = 1'b1;
        end
        if (i_cmd.sx_emit) begin
            n_out_valid = 1'b1;
            n_kind      = KIND_SYSEX;
            n_b0        = ram_rd_data;
            n_b1        = '0;
            n_b2        = '0;
            n_len       = 2'd1;
            n_last      = sx_done && !msg_emit;
        end
        if (i_cmd.msg_commit && msg_emit) begin
            n_out_valid = 1'b1;
            n_kind      = KIND_SHORT;
            n_b0        = new_mb[0];
            n_b1        = (eff_exp >= 2'd2) ? new_mb[1] : 8'd0;
            n_b2        = (eff_exp == 2'd3) ? new_mb[2] : 8'd0;
            n_len       = eff_exp;
            n_last      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs        <= '0;
            r_exp       <= '0;
            r_fill      <= '0;
            r_mb        <= '{default: '0};
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rs        <= n_rs;
            r_exp       <= n_exp;
            r_fill      <= n_fill;
            r_mb        <= n_mb;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_byte <= i_data_byte;
        end
        r_idx  <= n_idx;
        r_kind <= n_kind;
        r_b0   <= n_b0;
        r_b1   <= n_b1;
        r_b2   <= n_b2;
        r_len  <= n_len;
        r_last <= n_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_byte_zero  = r_b0;
    assign o_byte_one   = r_b1;
    assign o_byte_two   = r_b2;
    assign o_msg_length = r_len;
    assign o_last       = r_last;

endmodule

// ----- rtl/mbsf_ctrl.sv -----
// Controller of the framer: sequences byte intake, decode, sysex read-out
// and message framing. Depends on mbsf_pkg.
module mbsf_ctrl import mbsf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output t_state  o_state
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_status.is_rt) begin
                    if (i_status.slot_free) begin
                        n_state = ST_IDLE;
                    end
                end else if (i_status.rs_sysex && !i_status.is_status) begin
                    n_state = ST_IDLE;
                end else if (i_status.rs_sysex) begin
                    n_state = ST_SX_READ;
                end else if (!i_status.msg_emit || i_status.slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SX_READ: begin
                n_state = ST_SX_SEND;
            end
            ST_SX_SEND: begin
                if (i_status.slot_free) begin
                    n_state = i_status.sx_done ? ST_MSG : ST_SX_READ;
                end
            end
            ST_MSG: begin
                if (!i_status.msg_emit || i_status.slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall      = 1'b0;
                o_cmd.load_byte = i_in_valid;
            end
            ST_DECODE: begin
                if (i_status.is_rt) begin
                    o_cmd.rt_emit = i_status.slot_free;
                end else if (i_status.rs_sysex && !i_status.is_status) begin
                    o_cmd.sx_store = 1'b1;
                end else if (i_status.rs_sysex) begin
                    o_cmd.sx_close = 1'b1;
                end else begin
                    o_cmd.msg_commit = !i_status.msg_emit || i_status.slot_free;
                end
            end
            ST_SX_READ: begin
                o_cmd.sx_read = 1'b1;
            end
            ST_SX_SEND: begin
                o_cmd.sx_emit = i_status.slot_free;
            end
            ST_MSG: begin
                o_cmd.msg_commit = !i_status.msg_emit || i_status.slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

// ----- rtl/midi_byte_stream_framer_unit.sv -----
// MIDI byte stream framer, top level. Depends on mbsf_pkg, mbsf_ctrl,
// mbsf_datapath.
// A realtime byte or completing data/status byte enters the byte register, is
// decoded, then loads the output register once the slot is free; input stalls.
// Closing a sysex adds a RAM read and an output beat per stored byte. Synchronous
// active-low reset clears state, status and counts, not byte or output data.
module midi_byte_stream_framer_unit import mbsf_pkg::*; #(
    parameter int SYSEX_CAPACITY = SYSEX_CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_byte_zero,
    output logic [7:0] o_byte_one,
    output logic [7:0] o_byte_two,
    output logic [1:0] o_msg_length,
    output logic       o_last
);

    t_cmd    cmd;
    t_status status;
    t_state  state;

    mbsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall),
        .o_state    (state)
    );

    mbsf_datapath #(
        .SYSEX_CAPACITY (SYSEX_CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_data_byte  (i_data_byte),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_kind       (o_kind),
        .o_byte_zero  (o_byte_zero),
        .o_byte_one   (o_byte_one),
        .o_byte_two   (o_byte_two),
        .o_msg_length (o_msg_length),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while decode pending");

    a_load_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.rt_emit || cmd.sx_emit || (cmd.msg_commit && status.msg_emit))
        |-> status.slot_free)
        else $error("output register overwritten");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_msg_length != 2'd0))
        else $error("result beat with zero length");

    a_send_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == ST_SX_SEND) |-> ($past(state) == ST_SX_READ || $past(state) == ST_SX_SEND))
        else $error("sysex beat without RAM read");
`endif

endmodule
